// ===== design/sphdp_pkg.sv =====
// shared types, constants and microcode program for the sph density and pressure block
package sphdp_pkg;

    // position format and scaling of the squared distance to Q8.24
    localparam int POSITION_FRAC_BITS = 12;
    localparam int POS_W    = 16;
    localparam int SUM_W    = 2 * POS_W + 1;
    localparam int FRAC2    = 2 * POSITION_FRAC_BITS;
    localparam bit R2_RIGHT = (FRAC2 >= 24);
    localparam int R2_SHIFT = R2_RIGHT ? (FRAC2 - 24) : (24 - FRAC2);
    localparam int R2_EXT_W = SUM_W + (R2_RIGHT ? 0 : R2_SHIFT);

    // input request payload
    typedef struct packed {
        logic [15:0] self_x;
        logic [15:0] self_y;
        logic [15:0] other_x;
        logic [15:0] other_y;
        logic [15:0] other_mass;
        logic        last_neighbour;
        logic        new_step;
    } t_in_item;

    // result payload
    typedef struct packed {
        logic [31:0] density;
        logic [31:0] pressure;
        logic [31:0] least_density;
        logic [31:0] greatest_density;
        logic [31:0] least_pressure;
        logic [31:0] greatest_pressure;
    } t_out_item;

    // configuration registers
    typedef struct packed {
        logic [31:0] radius_squared;
        logic [31:0] kernel_scale;
        logic [23:0] stiffness;
        logic [31:0] rest_level;
    } t_cfg;

    // register indexes of the apb map, at byte address 4*index
    typedef enum logic [1:0] {
        REG_RADIUS,
        REG_SCALE,
        REG_STIFFNESS,
        REG_REST
    } t_cfg_reg;

    // datapath operations, one per microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_SQX,
        OP_SQY,
        OP_DIST,
        OP_D2,
        OP_D3L,
        OP_D3H,
        OP_WL,
        OP_WH,
        OP_MASS,
        OP_PRES,
        OP_EMIT
    } t_op;

    // sequencing of the step counter
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_BR_OUTSIDE,
        SEQ_STOP_IF_NOT_LAST,
        SEQ_STOP
    } t_seq;

    localparam int UC_LEN  = 11;
    localparam int UC_PC_W = $clog2(UC_LEN);

    typedef logic [UC_PC_W-1:0] t_pc;

    // step addresses
    localparam t_pc PC_SQX  = t_pc'(0);
    localparam t_pc PC_SQY  = t_pc'(1);
    localparam t_pc PC_DIST = t_pc'(2);
    localparam t_pc PC_D2   = t_pc'(3);
    localparam t_pc PC_D3L  = t_pc'(4);
    localparam t_pc PC_D3H  = t_pc'(5);
    localparam t_pc PC_WL   = t_pc'(6);
    localparam t_pc PC_WH   = t_pc'(7);
    localparam t_pc PC_MASS = t_pc'(8);
    localparam t_pc PC_PRES = t_pc'(9);
    localparam t_pc PC_EMIT = t_pc'(10);

    // one control word
    typedef struct packed {
        t_op  op;
        t_seq seq;
        t_pc  target;
        logic out_wait;
    } t_uword;

    // control from sequencer to datapath
    typedef struct packed {
        logic load;
        t_op  op;
    } t_ctrl;

    // status from datapath back to sequencer
    typedef struct packed {
        logic outside;
        logic last;
    } t_status;

    // microcode program rom
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{op: OP_NOP, seq: SEQ_STOP, target: PC_SQX, out_wait: 1'b0};
        case (pc)
            PC_SQX:  w = '{op: OP_SQX,  seq: SEQ_NEXT,       target: PC_SQX,  out_wait: 1'b0};
            PC_SQY:  w = '{op: OP_SQY,  seq: SEQ_NEXT,       target: PC_SQX,  out_wait: 1'b0};
            PC_DIST: w = '{op: OP_DIST, seq: SEQ_BR_OUTSIDE, target: PC_MASS, out_wait: 1'b0};
            PC_D2:   w = '{op: OP_D2,   seq: SEQ_NEXT,       target: PC_SQX,  out_wait: 1'b0};
            PC_D3L:  w = '{op: OP_D3L,  seq: SEQ_NEXT,       target: PC_SQX,  out_wait: 1'b0};
            PC_D3H:  w = '{op: OP_D3H,  seq: SEQ_NEXT,       target: PC_SQX,  out_wait: 1'b0};
            PC_WL:   w = '{op: OP_WL,   seq: SEQ_NEXT,       target: PC_SQX,  out_wait: 1'b0};
            PC_WH:   w = '{op: OP_WH,   seq: SEQ_NEXT,       target: PC_SQX,  out_wait: 1'b0};
            PC_MASS: w = '{op: OP_MASS, seq: SEQ_STOP_IF_NOT_LAST,
                           target: PC_SQX, out_wait: 1'b0};
            PC_PRES: w = '{op: OP_PRES, seq: SEQ_NEXT,       target: PC_SQX,  out_wait: 1'b0};
            PC_EMIT: w = '{op: OP_EMIT, seq: SEQ_STOP,       target: PC_SQX,  out_wait: 1'b1};
            default: w = '{op: OP_NOP,  seq: SEQ_STOP,       target: PC_SQX,  out_wait: 1'b0};
        endcase
        return w;
    endfunction

endpackage

// ===== design/sphdp_regs.sv =====
// apb configuration registers of the sph density and pressure block
module sphdp_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output sphdp_pkg::t_cfg      o_cfg
);

    sphdp_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius_squared <= 32'd16777216;
            r_cfg.kernel_scale   <= 32'd65536;
            r_cfg.stiffness      <= 24'd128000;
            r_cfg.rest_level     <= 32'd6553600;
        end else if (wr_en) begin
            unique case (reg_idx)
                sphdp_pkg::REG_RADIUS:    r_cfg.radius_squared <= pwdata;
                sphdp_pkg::REG_SCALE:     r_cfg.kernel_scale   <= pwdata;
                sphdp_pkg::REG_STIFFNESS: r_cfg.stiffness      <= pwdata[23:0];
                sphdp_pkg::REG_REST:      r_cfg.rest_level     <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            sphdp_pkg::REG_RADIUS:    prdata = r_cfg.radius_squared;
            sphdp_pkg::REG_SCALE:     prdata = r_cfg.kernel_scale;
            sphdp_pkg::REG_STIFFNESS: prdata = {8'd0, r_cfg.stiffness};
            sphdp_pkg::REG_REST:      prdata = r_cfg.rest_level;
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/sphdp_datapath.sv =====
// shared-multiplier datapath: kernel, density sum, pressure and step trackers
module sphdp_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sphdp_pkg::t_ctrl      i_ctrl,
    input  sphdp_pkg::t_in_item   i_item,
    input  sphdp_pkg::t_cfg       i_cfg,
    output sphdp_pkg::t_status    o_status,
    output sphdp_pkg::t_out_item  o_result
);

    sphdp_pkg::t_in_item r_item;
    logic [sphdp_pkg::SUM_W-1:0] r_sum;
    logic [31:0] r_d;
    logic [39:0] r_d2;
    logic [63:0] r_part;
    logic [47:0] r_d3;
    logic [31:0] r_w;
    logic [31:0] r_dsum;
    logic [31:0] r_pres;
    logic [31:0] r_min_d, r_max_d, r_min_p, r_max_p;

    logic [15:0] dx, dy;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [sphdp_pkg::R2_EXT_W-1:0] sum_ext, scaled;
    logic [31:0] r2;
    logic        outside;
    logic [71:0] t72;
    logic [79:0] t80;
    logic [31:0] w_sat;
    logic [40:0] acc41;
    logic [31:0] n_dsum;
    logic [31:0] rest_diff;
    logic        above_rest;
    logic [31:0] pres_sat;
    logic [31:0] n_min_d, n_max_d, n_min_p, n_max_p;

    // coordinate differences
    assign dx = (r_item.self_x >= r_item.other_x) ? (r_item.self_x - r_item.other_x)
                                                  : (r_item.other_x - r_item.self_x);
    assign dy = (r_item.self_y >= r_item.other_y) ? (r_item.self_y - r_item.other_y)
                                                  : (r_item.other_y - r_item.self_y);
    assign rest_diff  = r_dsum - i_cfg.rest_level;
    assign above_rest = r_dsum > i_cfg.rest_level;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.op)
            sphdp_pkg::OP_SQX: begin
                mul_a = {16'd0, dx};
                mul_b = {16'd0, dx};
            end
            sphdp_pkg::OP_SQY: begin
                mul_a = {16'd0, dy};
                mul_b = {16'd0, dy};
            end
            sphdp_pkg::OP_D2: begin
                mul_a = r_d;
                mul_b = r_d;
            end
            sphdp_pkg::OP_D3L: begin
                mul_a = r_d2[31:0];
                mul_b = r_d;
            end
            sphdp_pkg::OP_D3H: begin
                mul_a = {24'd0, r_d2[39:32]};
                mul_b = r_d;
            end
            sphdp_pkg::OP_WL: begin
                mul_a = r_d3[31:0];
                mul_b = i_cfg.kernel_scale;
            end
            sphdp_pkg::OP_WH: begin
                mul_a = {16'd0, r_d3[47:32]};
                mul_b = i_cfg.kernel_scale;
            end
            sphdp_pkg::OP_MASS: begin
                mul_a = {16'd0, r_item.other_mass};
                mul_b = r_w;
            end
            sphdp_pkg::OP_PRES: begin
                mul_a = {8'd0, i_cfg.stiffness};
                mul_b = rest_diff;
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // squared distance rescaled to q8.24, saturated
    assign sum_ext = {{(sphdp_pkg::R2_EXT_W - sphdp_pkg::SUM_W){1'b0}}, r_sum};
    always_comb begin
        if (sphdp_pkg::R2_RIGHT) begin
            scaled = sum_ext >> sphdp_pkg::R2_SHIFT;
        end else begin
            scaled = sum_ext << sphdp_pkg::R2_SHIFT;
        end
    end
    assign r2      = (|scaled[sphdp_pkg::R2_EXT_W-1:32]) ? 32'hFFFF_FFFF : scaled[31:0];
    assign outside = r2 > i_cfg.radius_squared;

    // high partial products joined with the stored low ones
    assign t72   = {prod[39:0], 32'd0} + {8'd0, r_part};
    assign t80   = {prod[47:0], 32'd0} + {16'd0, r_part};
    assign w_sat = (|t80[79:56]) ? 32'hFFFF_FFFF : t80[55:24];

    // density accumulate with saturation
    assign acc41  = {9'd0, r_dsum} + {1'b0, prod[47:8]};
    assign n_dsum = (|acc41[40:32]) ? 32'hFFFF_FFFF : acc41[31:0];

    // pressure, saturated at the top; clamped at zero at or below the rest level
    assign pres_sat = (|prod[63:40]) ? 32'hFFFF_FFFF : prod[39:8];

    // tracker candidates
    assign n_min_d = (r_dsum < r_min_d) ? r_dsum : r_min_d;
    assign n_max_d = (r_dsum > r_max_d) ? r_dsum : r_max_d;
    assign n_min_p = (r_pres < r_min_p) ? r_pres : r_min_p;
    assign n_max_p = (r_pres > r_max_p) ? r_pres : r_max_p;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_item <= i_item;
        end
        case (i_ctrl.op)
            sphdp_pkg::OP_SQX:  r_sum  <= prod[sphdp_pkg::SUM_W-1:0];
            sphdp_pkg::OP_SQY:  r_sum  <= r_sum + prod[sphdp_pkg::SUM_W-1:0];
            sphdp_pkg::OP_DIST: begin
                r_d <= i_cfg.radius_squared - r2;
                if (outside) begin
                    r_w <= '0;
                end
            end
            sphdp_pkg::OP_D2:   r_d2   <= prod[63:24];
            sphdp_pkg::OP_D3L:  r_part <= prod;
            sphdp_pkg::OP_D3H:  r_d3   <= t72[71:24];
            sphdp_pkg::OP_WL:   r_part <= prod;
            sphdp_pkg::OP_WH:   r_w    <= w_sat;
            sphdp_pkg::OP_PRES: r_pres <= above_rest ? pres_sat : 32'd0;
            default: ;
        endcase
    end

    // density sum and step trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dsum  <= '0;
            r_min_d <= '1;
            r_max_d <= '0;
            r_min_p <= '1;
            r_max_p <= '0;
        end else begin
            if (i_ctrl.load && i_item.new_step) begin
                r_min_d <= '1;
                r_max_d <= '0;
                r_min_p <= '1;
                r_max_p <= '0;
            end else if (i_ctrl.op == sphdp_pkg::OP_EMIT) begin
                r_min_d <= n_min_d;
                r_max_d <= n_max_d;
                r_min_p <= n_min_p;
                r_max_p <= n_max_p;
            end
            if (i_ctrl.op == sphdp_pkg::OP_MASS) begin
                r_dsum <= n_dsum;
            end else if (i_ctrl.op == sphdp_pkg::OP_EMIT) begin
                r_dsum <= '0;
            end
        end
    end

    assign o_status.outside = outside;
    assign o_status.last    = r_item.last_neighbour;

    assign o_result.density           = r_dsum;
    assign o_result.pressure          = r_pres;
    assign o_result.least_density     = n_min_d;
    assign o_result.greatest_density  = n_max_d;
    assign o_result.least_pressure    = n_min_p;
    assign o_result.greatest_pressure = n_max_p;

endmodule

// ===== design/sph_density_pressure.sv =====
// top level of the sph poly6 density and pressure block
//
// input channel: one particle/neighbour pair per request (i_in_valid, o_in_stall,
// i_in_data). pairs of one particle arrive in sequence, the last one flagged by
// last_neighbour; new_step on a pair clears the per-step minimum and maximum.
// output channel: one result per particle (o_out_valid, i_out_stall, o_out_data),
// held in an output register until taken.
// timing: a microcoded sequencer drives one shared 32x32 multiplier, one step
// per cycle unless the emit step is held. a pair inside the radius runs the
// squares of x and y, distance, d^2, d^3 and scale in two halves each, and mass;
// a pair outside the radius goes from distance straight to mass; a last pair adds
// pressure and emit, with its result valid in the cycle after the emit step.
// no new pair is accepted until the steps of the current one are done.
// stall: the emit step waits while the previous result is still stalled; new
// pairs may be accepted while a result waits.
// reset: synchronous, active low; loads register defaults, clears the density
// sum and the trackers, and empties the output register.
// config: apb writes at byte address 4*i, by the user only while the block is idle (not enforced).
module sph_density_pressure (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sphdp_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sphdp_pkg::t_out_item  o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    sphdp_pkg::t_cfg      cfg;
    sphdp_pkg::t_ctrl     ctrl;
    sphdp_pkg::t_status   status;
    sphdp_pkg::t_out_item result;
    sphdp_pkg::t_uword    uw;
    sphdp_pkg::t_out_item r_odata;

    logic               r_busy;
    sphdp_pkg::t_pc     r_pc;
    sphdp_pkg::t_pc     n_pc;
    logic               r_ovalid;
    logic               in_accept;
    logic               step_hold;
    logic               exec;
    logic               emit;

    sphdp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sphdp_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_status (status),
        .o_result (result)
    );

    // control word fetch and step enable
    assign uw        = sphdp_pkg::ucode(r_pc);
    assign step_hold = uw.out_wait && r_ovalid && i_out_stall;
    assign exec      = r_busy && !step_hold;
    assign emit      = exec && (uw.op == sphdp_pkg::OP_EMIT);
    assign in_accept = i_in_valid && !r_busy;
    assign n_pc      = r_pc + 1'b1;

    assign ctrl.load = in_accept;
    assign ctrl.op   = exec ? uw.op : sphdp_pkg::OP_NOP;

    // step counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= sphdp_pkg::PC_SQX;
        end else if (in_accept) begin
            r_busy <= 1'b1;
            r_pc   <= sphdp_pkg::PC_SQX;
        end else if (exec) begin
            case (uw.seq)
                sphdp_pkg::SEQ_NEXT:       r_pc <= n_pc;
                sphdp_pkg::SEQ_BR_OUTSIDE: r_pc <= status.outside ? uw.target : n_pc;
                sphdp_pkg::SEQ_STOP_IF_NOT_LAST: begin
                    if (status.last) begin
                        r_pc <= n_pc;
                    end else begin
                        r_busy <= 1'b0;
                    end
                end
                default: r_busy <= 1'b0;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_odata <= result;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // a result appears only after an emit step
    a_rise_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_ovalid) && $past(i_rst_n)) |-> $past(emit))
        else $error("output valid rose without an emit step");

    // emit never overwrites a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !(r_ovalid && i_out_stall))
        else $error("emit overwrote a pending result");

    // the sequencer finishes only at a stop step
    a_stop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_busy) && $past(i_rst_n)) |->
        $past(exec && (uw.seq == sphdp_pkg::SEQ_STOP ||
                       uw.seq == sphdp_pkg::SEQ_STOP_IF_NOT_LAST)))
        else $error("sequencer ended outside a stop step");

    // step counter stays inside the program while busy
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= sphdp_pkg::PC_EMIT))
        else $error("step counter left the program");

endmodule

// ===== dv/tb_sph_density_pressure.sv =====
// testbench for sph_density_pressure: directed and random pairs checked against a local predictor
`timescale 1ns / 100ps

module tb_sph_density_pressure;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 20;
    localparam int PHASE_PAIRS  = 180;
    localparam int PHASE_COUNT  = 8;

    // density and pressure predictor with its store of pending particle results
    class density_scoreboard;
        bit [31:0] radius_sq;
        bit [31:0] kernel_scale;
        bit [23:0] stiffness;
        bit [31:0] rest_level;
        bit [31:0] density_sum;
        bit [31:0] min_density;
        bit [31:0] max_density;
        bit [31:0] min_pressure;
        bit [31:0] max_pressure;
        sphdp_pkg::t_out_item particle_q[$];
        int        errors;
        int        pairs_seen;
        int        results_seen;
        string     field_name[6] = '{"density", "pressure", "least_density",
                                     "greatest_density", "least_pressure",
                                     "greatest_pressure"};

        function new();
            radius_sq    = 32'd16777216;
            kernel_scale = 32'd65536;
            stiffness    = 24'd128000;
            rest_level   = 32'd6553600;
            density_sum  = '0;
            min_density  = '1;
            max_density  = '0;
            min_pressure = '1;
            max_pressure = '0;
            errors       = 0;
            pairs_seen   = 0;
            results_seen = 0;
        endfunction

        function void set_register(sphdp_pkg::t_cfg_reg idx, bit [31:0] value);
            case (idx)
                sphdp_pkg::REG_RADIUS:    radius_sq    = value;
                sphdp_pkg::REG_SCALE:     kernel_scale = value;
                sphdp_pkg::REG_STIFFNESS: stiffness    = value[23:0];
                sphdp_pkg::REG_REST:      rest_level   = value;
                default:                  ;
            endcase
        endfunction

        function bit [31:0] clip32(bit [63:0] v);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        // (a * b) >> 24 with a saturating 64 bit result
        function bit [63:0] product_q24(bit [63:0] a, bit [31:0] b);
            bit [127:0] p;
            p = {64'd0, a} * {96'd0, b};
            if ((p >> 88) != 0)
                return '1;
            p = p >> 24;
            return p[63:0];
        endfunction

        // squared distance rescaled to Q8.24, saturated
        function bit [31:0] distance_sq(sphdp_pkg::t_in_item p);
            bit [63:0] dx;
            bit [63:0] dy;
            bit [63:0] total;
            dx = (p.self_x >= p.other_x) ? p.self_x - p.other_x : p.other_x - p.self_x;
            dy = (p.self_y >= p.other_y) ? p.self_y - p.other_y : p.other_y - p.self_y;
            total = dx * dx + dy * dy;
            if (2 * sphdp_pkg::POSITION_FRAC_BITS >= 24)
                total = total >> (2 * sphdp_pkg::POSITION_FRAC_BITS - 24);
            else
                total = total << (24 - 2 * sphdp_pkg::POSITION_FRAC_BITS);
            return clip32(total);
        endfunction

        // poly6 weight, zero outside the smoothing radius
        function bit [31:0] poly6_weight(bit [31:0] r2);
            bit [63:0] d;
            bit [63:0] d2;
            bit [63:0] d3;
            if (r2 > radius_sq)
                return '0;
            d  = {32'd0, radius_sq - r2};
            d2 = (d * d) >> 24;
            d3 = product_q24(d2, d[31:0]);
            return clip32(product_q24(d3, kernel_scale));
        endfunction

        function void note_pair(sphdp_pkg::t_in_item p);
            bit [31:0] w;
            bit [63:0] contrib;
            bit [31:0] dens;
            bit [31:0] pres;
            sphdp_pkg::t_out_item res;
            pairs_seen++;
            if (p.new_step) begin
                min_density  = '1;
                max_density  = '0;
                min_pressure = '1;
                max_pressure = '0;
            end
            w = poly6_weight(distance_sq(p));
            contrib = ({48'd0, p.other_mass} * {32'd0, w}) >> 8;
            density_sum = clip32({32'd0, density_sum} + contrib);
            if (!p.last_neighbour)
                return;
            dens = density_sum;
            if (dens > rest_level)
                pres = clip32(({40'd0, stiffness} * {32'd0, dens - rest_level}) >> 8);
            else
                pres = '0;
            if (dens < min_density)  min_density  = dens;
            if (pres < min_pressure) min_pressure = pres;
            if (dens > max_density)  max_density  = dens;
            if (pres > max_pressure) max_pressure = pres;
            res.density           = dens;
            res.pressure          = pres;
            res.least_density     = min_density;
            res.greatest_density  = max_density;
            res.least_pressure    = min_pressure;
            res.greatest_pressure = max_pressure;
            particle_q.insert(particle_q.size(), res);
            density_sum = '0;
        endfunction

        function void check_result(sphdp_pkg::t_out_item got);
            sphdp_pkg::t_out_item want;
            logic [191:0] g;
            logic [191:0] e;
            results_seen++;
            if (particle_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h, no particle pending", $time, got);
                return;
            end
            want = particle_q.pop_front();
            g = got;
            e = want;
            for (int i = 0; i < 6; i++) begin
                if (g[191 - 32*i -: 32] !== e[191 - 32*i -: 32]) begin
                    errors++;
                    $display("%0t: %s mismatch, expected %h, got %h", $time,
                             field_name[i], e[191 - 32*i -: 32], g[191 - 32*i -: 32]);
                end
            end
        endfunction

        function int pending();
            return particle_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    sphdp_pkg::t_in_item  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    sphdp_pkg::t_out_item o_out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    density_scoreboard sb;
    int idle_pct;
    int hold_request;
    int settings_used;

    sph_density_pressure u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall, long hold-off on request, check every taken result
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall)
                sb.check_result(o_out_data);
            @(negedge i_clk);
            if (hold_left == 0 && hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("sph_density_pressure verification failed");
        $finish;
    end

    // one request on the pair channel, with a random gap ahead of it
    task automatic send_pair(sphdp_pkg::t_in_item p);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap++;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        sb.note_pair(p);
    endtask

    // stop sending and wait for every pending particle result
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(sphdp_pkg::t_cfg_reg idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready)
                break;
        end
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // all four registers, only once the block has gone quiet
    task automatic apply_config(logic [31:0] h2, logic [31:0] scale, logic [23:0] stiff,
                                logic [31:0] rest);
        drain();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        write_register(sphdp_pkg::REG_RADIUS, h2);
        write_register(sphdp_pkg::REG_SCALE, scale);
        write_register(sphdp_pkg::REG_STIFFNESS, {8'd0, stiff});
        write_register(sphdp_pkg::REG_REST, rest);
        settings_used++;
    endtask

    function automatic sphdp_pkg::t_in_item make_pair(int sx, int sy, int ox, int oy,
                                                      int mass, bit last, bit fresh);
        sphdp_pkg::t_in_item p;
        p.self_x         = 16'(sx);
        p.self_y         = 16'(sy);
        p.other_x        = 16'(ox);
        p.other_y        = 16'(oy);
        p.other_mass     = 16'(mass);
        p.last_neighbour = last;
        p.new_step       = fresh;
        return p;
    endfunction

    // integer square root, gives the radius in position steps
    function automatic int unsigned root_of(bit [31:0] v);
        bit [63:0] r;
        bit [63:0] t;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= {32'd0, v})
                r = t;
        end
        return r[31:0];
    endfunction

    // a coordinate within reach of the centre, clamped to the field range
    function automatic int nearby(int centre, int unsigned reach);
        int off;
        int v;
        off = $urandom_range(0, reach);
        v = $urandom_range(0, 1) ? centre + off : centre - off;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v;
    endfunction

    // one particle with its neighbours, or now and then a stray pair
    task automatic send_group(int unsigned reach, inout int count);
        sphdp_pkg::t_in_item p;
        int n;
        int sx;
        int sy;
        if ($urandom_range(0, 9) == 0) begin
            p = make_pair($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 1),
                          ($urandom_range(0, 7) == 0));
            send_pair(p);
            count++;
            return;
        end
        n  = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        sx = $urandom_range(0, 65535);
        sy = $urandom_range(0, 65535);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) != 0)
                p = make_pair(sx, sy, nearby(sx, reach), nearby(sy, reach), 0, 0, 0);
            else
                p = make_pair(sx, sy, $urandom_range(0, 65535), $urandom_range(0, 65535),
                              0, 0, 0);
            p.other_mass = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 16'h2000));
            p.last_neighbour = (k == n - 1);
            p.new_step = (k == 0 && $urandom_range(0, 9) == 0);
            send_pair(p);
            count++;
        end
    endtask

    // main sequence
    initial begin
        int sent;
        int unsigned reach;
        logic [31:0] h2;
        logic [31:0] scale;
        sb = new();
        idle_pct      = 20;
        hold_request  = 0;
        settings_used = 1;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: full mass at one spot, far pair, radius edge, rest level
        send_pair(make_pair(16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'hFFFF, 1, 1));
        send_pair(make_pair(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0));
        send_pair(make_pair(16'h2000, 16'h2000, 16'h3000, 16'h2000, 16'h0100, 0, 0));
        send_pair(make_pair(16'h2000, 16'h2000, 16'h3000, 16'h2001, 16'h0100, 1, 0));
        send_pair(make_pair(16'h4000, 16'h4000, 16'h4000, 16'h4000, 25600, 1, 0));
        send_pair(make_pair(16'h4000, 16'h4000, 16'h4000, 16'h4000, 25601, 1, 0));
        send_pair(make_pair(16'h5000, 16'h5000, 16'h5000, 16'h5000, 0, 0, 1));
        send_pair(make_pair(16'h5000, 16'h5000, 16'h5800, 16'h5800, 16'h4000, 0, 0));
        send_pair(make_pair(16'h5800, 16'h5800, 16'h5000, 16'h5000, 16'h8000, 1, 0));
        send_pair(make_pair(16'h6000, 16'h6000, 16'h6000, 16'h6000, 25600, 1, 0));

        // everything at its top: saturated weight, density and pressure
        apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 32'd0);
        send_pair(make_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 1, 1));
        send_pair(make_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 0, 0));
        send_pair(make_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1, 0));
        send_pair(make_pair(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0));

        // everything at its bottom: zero radius, zero scale, rest at maximum
        apply_config(32'd0, 32'd0, 24'd0, 32'hFFFF_FFFF);
        send_pair(make_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1));
        send_pair(make_pair(16'h1234, 16'h1234, 16'h1235, 16'h1234, 16'hFFFF, 1, 0));

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph == 0) begin
                apply_config(32'd16777216, 32'd65536, 24'd128000, 32'd6553600);
            end else begin
                h2 = (ph == 6) ? $urandom : $urandom_range(1 << 20, 1 << 28);
                scale = $urandom_range(0, 1) ? $urandom_range(1 << 12, 1 << 20) : $urandom;
                apply_config(h2, scale, 24'($urandom_range(0, 24'hFFFFFF)),
                             $urandom_range(0, 1 << 26));
            end
            reach = root_of(sb.radius_sq) * 7 / 10;
            idle_pct = (ph == 5) ? 0 : 20;
            // output held off long enough for the input to back up
            if (ph == 3)
                hold_request = HOLD_CYCLES;
            sent = 0;
            while (sent < PHASE_PAIRS) begin
                // mid-phase pause until the result side has caught up
                if (ph == 4 && sent >= PHASE_PAIRS / 2 && sent < PHASE_PAIRS / 2 + 4)
                    drain();
                send_group(reach, sent);
            end
        end

        drain();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d particle results never arrived", $time, sb.pending());
        end
        $display("run covered %0d pairs and %0d particle results over %0d register settings",
                 sb.pairs_seen, sb.results_seen, settings_used);
        $display("including a %0d cycle output hold-off, a full drain and a no-idle phase",
                 HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("sph_density_pressure verification clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("sph_density_pressure verification failed");
        end
        $finish;
    end

endmodule
